// File: rtl/radical_inverse_generator_macros.svh
// Assertion macros shared by the radical inverse generator RTL.
`ifndef RADICAL_INVERSE_GENERATOR_MACROS_SVH
`define RADICAL_INVERSE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RIG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RIG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rig_pkg.sv
package rig_pkg;

   // Field and datapath widths
   localparam int INDEX_BITS       = 31;
   localparam int FRACTION_BITS    = 32;
   localparam int RADIX_BITS       = 7;
   localparam int RADIX_MIN        = 2;
   localparam int RADIX_MAX        = 64;
   localparam int RADIX_LOG        = 6;   // ceil(log2(RADIX_MAX))
   localparam int FRAC_FIELD_BITS  = 32;
   localparam int COUNT_FIELD_BITS = 5;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(2);

   // Reciprocal is below 2^(INDEX_BITS+1) for every radix in range
   localparam int REC_BITS   = INDEX_BITS + 1;
   localparam int PROD_BITS  = INDEX_BITS + REC_BITS;
   // radix^k <= radix * index < 2^(INDEX_BITS+RADIX_LOG)
   localparam int ACC_BITS   = INDEX_BITS + RADIX_LOG;
   localparam int REM_BITS   = ACC_BITS + 1;
   localparam int COUNT_BITS = $clog2(INDEX_BITS + 1);
   localparam int STEP_BITS  = $clog2(FRACTION_BITS);
   localparam int SHIFT_BITS = $clog2(INDEX_BITS + RADIX_LOG + 1);

   typedef logic [REC_BITS-1:0]   recip_table_type [0:RADIX_MAX];
   typedef logic [SHIFT_BITS-1:0] shift_table_type [0:RADIX_MAX];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIG,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } rig_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic mul_step;
      logic dig_step;
      logic prep;
      logic div_step;
      logic out_load;
   } rig_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic n_zero;
   } rig_status_type;

   // Smallest l with 2^l >= v
   function automatic int ceil_log2(input int v);
      int l;
      l = 0;
      for (int i = 0; i < 8; i++) begin
         if ((1 << i) < v) begin
            l = i + 1;
         end
      end
      return l;
   endfunction

   // m = ceil(2^(INDEX_BITS+l) / b): exact quotient for any index below 2^INDEX_BITS
   function automatic recip_table_type build_recip_table();
      recip_table_type t;
      logic [63:0]     num;
      logic [63:0]     quo;
      logic [63:0]     rem;
      int              l;
      for (int b = 0; b <= RADIX_MAX; b++) begin
         if (b < RADIX_MIN) begin
            t[b] = '0;
         end else begin
            l   = ceil_log2(b);
            num = 64'd1 << (INDEX_BITS + l);
            quo = '0;
            rem = '0;
            for (int i = 63; i >= 0; i--) begin
               rem = {rem[62:0], num[i]};
               if (rem >= 64'(b)) begin
                  rem    = rem - 64'(b);
                  quo[i] = 1'b1;
               end
            end
            if (rem != 64'd0) begin
               quo = quo + 64'd1;
            end
            t[b] = quo[REC_BITS-1:0];
         end
      end
      return t;
   endfunction

   function automatic shift_table_type build_shift_table();
      shift_table_type t;
      for (int b = 0; b <= RADIX_MAX; b++) begin
         t[b] = SHIFT_BITS'(INDEX_BITS + ceil_log2(b));
      end
      return t;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip_table();
   localparam shift_table_type SHIFT_TABLE = build_shift_table();

endpackage

// File: rtl/rig_controller.sv
module rig_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rig_pkg::rig_cmd_type  cmd,
   input  rig_pkg::rig_status_type status
);

   rig_pkg::rig_state_type state_ff, state_in;
   logic [rig_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rig_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         rig_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rig_pkg::ST_MUL;
            end
         end
         rig_pkg::ST_MUL: begin
            // Append the previous digit; start the next one unless index is used up
            cmd.mul_step = 1'b1;
            if (status.n_zero) begin
               state_in = rig_pkg::ST_PREP;
            end else begin
               state_in = rig_pkg::ST_DIG;
            end
         end
         rig_pkg::ST_DIG: begin
            cmd.dig_step = 1'b1;
            state_in     = rig_pkg::ST_MUL;
         end
         rig_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = rig_pkg::ST_DIV;
         end
         rig_pkg::ST_DIV: begin
            // One quotient bit per cycle
            cmd.div_step = 1'b1;
            step_in      = step_ff + rig_pkg::STEP_BITS'(1);
            if (step_ff == rig_pkg::STEP_BITS'(rig_pkg::FRACTION_BITS - 1)) begin
               state_in = rig_pkg::ST_DONE;
            end
         end
         rig_pkg::ST_DONE: begin
            // Wait for the output register to be free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rig_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rig_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != rig_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/rig_datapath.sv
module rig_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [rig_pkg::RADIX_BITS-1:0]        csr_write_data,
   input  logic [rig_pkg::INDEX_BITS-1:0]        req_sample_index,
   input  rig_pkg::rig_cmd_type                  cmd,
   output rig_pkg::rig_status_type               status,
   output logic [rig_pkg::FRAC_FIELD_BITS-1:0]   rsp_fraction,
   output logic [rig_pkg::COUNT_FIELD_BITS-1:0]  rsp_digit_count
);

   logic [rig_pkg::RADIX_BITS-1:0]       radix_ff;
   logic [rig_pkg::RADIX_BITS-1:0]       radix_eff;

   logic [rig_pkg::RADIX_BITS-1:0]       b_ff, b_in;
   logic [rig_pkg::REC_BITS-1:0]         recip_ff, recip_in;
   logic [rig_pkg::SHIFT_BITS-1:0]       shift_ff, shift_in;
   logic [rig_pkg::INDEX_BITS-1:0]       n_ff, n_in;
   logic [rig_pkg::PROD_BITS-1:0]        prod_ff, prod_in;
   logic [rig_pkg::RADIX_LOG-1:0]        digit_ff, digit_in;
   logic                                 pending_ff, pending_in;
   logic [rig_pkg::ACC_BITS-1:0]         rev_ff, rev_in;
   logic [rig_pkg::ACC_BITS-1:0]         scale_ff, scale_in;
   logic [rig_pkg::COUNT_BITS-1:0]       count_ff, count_in;
   logic [rig_pkg::REM_BITS-1:0]         rem_ff, rem_in;
   logic [rig_pkg::FRACTION_BITS-1:0]    frac_ff, frac_in;
   logic [rig_pkg::FRAC_FIELD_BITS-1:0]  fraction_ff, fraction_in;
   logic [rig_pkg::COUNT_FIELD_BITS-1:0] digit_count_ff, digit_count_in;

   logic [rig_pkg::PROD_BITS-1:0]                 prod_shifted;
   logic [rig_pkg::INDEX_BITS-1:0]                quotient;
   logic [rig_pkg::INDEX_BITS+rig_pkg::RADIX_BITS-1:0] q_times_b;
   logic [rig_pkg::REM_BITS-1:0]                  rem_shifted;
   logic                                          quo_bit;

   // Radix register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rig_pkg::RADIX_RESET;
      end else if (csr_write_enable) begin
         radix_ff <= csr_write_data;
      end
   end

   // Clamp to the supported range
   always_comb begin
      priority if (radix_ff < rig_pkg::RADIX_BITS'(rig_pkg::RADIX_MIN)) begin
         radix_eff = rig_pkg::RADIX_BITS'(rig_pkg::RADIX_MIN);
      end else if (radix_ff > rig_pkg::RADIX_BITS'(rig_pkg::RADIX_MAX)) begin
         radix_eff = rig_pkg::RADIX_BITS'(rig_pkg::RADIX_MAX);
      end else begin
         radix_eff = radix_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      b_ff           <= b_in;
      recip_ff       <= recip_in;
      shift_ff       <= shift_in;
      n_ff           <= n_in;
      prod_ff        <= prod_in;
      digit_ff       <= digit_in;
      pending_ff     <= pending_in;
      rev_ff         <= rev_in;
      scale_ff       <= scale_in;
      count_ff       <= count_in;
      rem_ff         <= rem_in;
      frac_ff        <= frac_in;
      fraction_ff    <= fraction_in;
      digit_count_ff <= digit_count_in;
   end

   // Digit split: q = (n * m) >> s is exact; remainder from the low bits
   assign prod_shifted = prod_ff >> shift_ff;
   assign quotient     = prod_shifted[rig_pkg::INDEX_BITS-1:0];
   assign q_times_b    = quotient * b_ff;

   // Restoring division step
   assign rem_shifted = {rem_ff[rig_pkg::REM_BITS-2:0], 1'b0};
   assign quo_bit     = (rem_shifted >= {1'b0, scale_ff});

   always_comb begin
      b_in           = b_ff;
      recip_in       = recip_ff;
      shift_in       = shift_ff;
      n_in           = n_ff;
      prod_in        = prod_ff;
      digit_in       = digit_ff;
      pending_in     = pending_ff;
      rev_in         = rev_ff;
      scale_in       = scale_ff;
      count_in       = count_ff;
      rem_in         = rem_ff;
      frac_in        = frac_ff;
      fraction_in    = fraction_ff;
      digit_count_in = digit_count_ff;

      // Start of a transaction
      if (cmd.load) begin
         b_in       = radix_eff;
         recip_in   = rig_pkg::RECIP_TABLE[radix_eff];
         shift_in   = rig_pkg::SHIFT_TABLE[radix_eff];
         n_in       = req_sample_index;
         pending_in = 1'b0;
         rev_in     = '0;
         scale_in   = rig_pkg::ACC_BITS'(1);
         count_in   = '0;
      end

      // Append the last digit and multiply by the reciprocal
      if (cmd.mul_step) begin
         prod_in    = n_ff * recip_ff;
         pending_in = 1'b0;
         if (pending_ff) begin
            rev_in   = rig_pkg::ACC_BITS'(rev_ff * b_ff) + rig_pkg::ACC_BITS'(digit_ff);
            scale_in = rig_pkg::ACC_BITS'(scale_ff * b_ff);
            count_in = count_ff + rig_pkg::COUNT_BITS'(1);
         end
      end

      // Take quotient and digit
      if (cmd.dig_step) begin
         n_in       = quotient;
         digit_in   = n_ff[rig_pkg::RADIX_LOG-1:0] - q_times_b[rig_pkg::RADIX_LOG-1:0];
         pending_in = 1'b1;
      end

      if (cmd.prep) begin
         rem_in  = rig_pkg::REM_BITS'(rev_ff);
         frac_in = '0;
      end

      if (cmd.div_step) begin
         if (quo_bit) begin
            rem_in = rem_shifted - {1'b0, scale_ff};
         end else begin
            rem_in = rem_shifted;
         end
         frac_in = {frac_ff[rig_pkg::FRACTION_BITS-2:0], quo_bit};
      end

      // Output register
      if (cmd.out_load) begin
         fraction_in    = rig_pkg::FRAC_FIELD_BITS'(frac_ff);
         digit_count_in = rig_pkg::COUNT_FIELD_BITS'(count_ff);
      end
   end

   assign status.n_zero   = (n_ff == '0);
   assign rsp_fraction    = fraction_ff;
   assign rsp_digit_count = digit_count_ff;

endmodule

// File: rtl/radical_inverse_generator.sv
// A transaction is accepted in idle; each base-radix digit of the index (k = 0..31 digits)
// passes through the reciprocal multiplier in the multiply and digit states, then the fraction
// comes one bit per cycle from the 32-step restoring divider before rsp_valid is raised.
// Only one transaction is in flight at a time; the next one is taken while a result waits.
// Reset (synchronous, active high) returns the controller to idle, drops rsp_valid and
// sets the radix register to 2.
`include "radical_inverse_generator_macros.svh"

module radical_inverse_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [rig_pkg::RADIX_BITS-1:0]        csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [rig_pkg::INDEX_BITS-1:0]        req_sample_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rig_pkg::FRAC_FIELD_BITS-1:0]   rsp_fraction,
   output logic [rig_pkg::COUNT_FIELD_BITS-1:0]  rsp_digit_count
);

   rig_pkg::rig_cmd_type    cmd;
   rig_pkg::rig_status_type status;

   rig_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rig_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_sample_index (req_sample_index),
      .cmd              (cmd),
      .status           (status),
      .rsp_fraction     (rsp_fraction),
      .rsp_digit_count  (rsp_digit_count)
   );

   // Checks
   `RIG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted transaction did not make the block busy")
   `RIG_ASSERT_NOW(a_single_command, clock, reset, 1'b1, $onehot0(cmd), "more than one datapath command at once")
   `RIG_ASSERT_NOW(a_no_result_overwrite, clock, reset, cmd.out_load, !rsp_valid || !rsp_stall, "pending result overwritten")

endmodule
